// ----- hdl/box_filter_image_downscaler_macros.svh -----
// ----------------------------------------------------------------------------
// Box filter downscaler assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH
`define BOX_FILTER_IMAGE_DOWNSCALER_MACROS_SVH

`ifndef SYNTH

// Check that prop holds at every clock edge out of reset.
`define BFD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("box filter assertion failed");

// Check that cond never holds out of reset.
`define BFD_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("box filter forbidden condition");

`else

`define BFD_ASSERT(label, prop)
`define BFD_ASSERT_NEVER(label, cond)

`endif

`endif

// ----- hdl/bfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Box filter downscaler package
// Shared widths, lane vector types, register codes and controller states.
// ----------------------------------------------------------------------------
package bfd_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;
	localparam int MAX_FACTOR     = 16;

	localparam int LANES       = 4;
	localparam int PIX_W       = 8;
	localparam int PART_W      = 12;
	localparam int SUM_W       = 16;
	localparam int CFG_W       = 11;
	localparam int FACT_W      = 5;
	localparam int CHCNT_W     = 3;
	localparam int AREA_W      = 2 * FACT_W;
	localparam int OUT_COORD_W = 10;
	localparam int REG_IDX_W   = 3;

	typedef logic [LANES-1:0][PIX_W-1:0]  byte_vec_t;
	typedef logic [LANES-1:0][PART_W-1:0] part_vec_t;
	typedef logic [LANES-1:0][SUM_W-1:0]  sum_vec_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SRC_WIDTH     = 3'd0,
		REG_SRC_HEIGHT    = 3'd1,
		REG_FACTOR_X      = 3'd2,
		REG_FACTOR_Y      = 3'd3,
		REG_CHANNEL_COUNT = 3'd4
	} cfg_reg_e;

	localparam logic [CHCNT_W-1:0] CH_RGBA = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MERGE,
		ST_DIV,
		ST_PUSH
	} bfd_state_t;

endpackage

// ----- hdl/box_filter_image_downscaler.sv -----
// ----------------------------------------------------------------------------
// Box filter image downscaler
// Averages raster-order 8-bit pixels over factor_x by factor_y blocks and
// emits one reduced pixel per complete block.
// ----------------------------------------------------------------------------
//
//  channel   handshake               payload
//  -------   ---------------------   --------------------------------------
//  pixel     pix_valid / pix_stall   chan_a, chan_b, chan_c, chan_d
//  result    res_valid / res_stall   avg_a..avg_d, out_col, out_row,
//                                    frame_last
//  config    wr_en                   wr_index, wr_data
//
//  A pixel that does not close a block leaves the controller idle. A pixel
//  that closes a block in a non-final band row adds a read-modify-write
//  (column sum read, then merge and write back). A pixel that closes a
//  block on the last band row adds the read-modify-write, the bit-serial
//  divider (eight quotient steps, then done) and the hand-over of the
//  average to the output register once it is free or draining.
//  Reset restores the register defaults and zeroes all position counters;
//  the column sum memory is not cleared, since row 0 of each band writes an
//  entry before any later row reads it. A stalled result waits in the output
//  register while the next pixels are accepted; only a second result that
//  finds the register full holds the pixel side.
// ----------------------------------------------------------------------------
`include "box_filter_image_downscaler_macros.svh"

module box_filter_image_downscaler #(
	parameter int MAX_WIDTH  = bfd_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bfd_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              wr_en,
	input  logic [bfd_pkg::REG_IDX_W-1:0]     wr_index,
	input  logic [bfd_pkg::CFG_W-1:0]         wr_data,
	// pixel channel
	input  logic                              pix_valid,
	output logic                              pix_stall,
	input  logic [bfd_pkg::PIX_W-1:0]         chan_a,
	input  logic [bfd_pkg::PIX_W-1:0]         chan_b,
	input  logic [bfd_pkg::PIX_W-1:0]         chan_c,
	input  logic [bfd_pkg::PIX_W-1:0]         chan_d,
	// result channel
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [bfd_pkg::PIX_W-1:0]         avg_a,
	output logic [bfd_pkg::PIX_W-1:0]         avg_b,
	output logic [bfd_pkg::PIX_W-1:0]         avg_c,
	output logic [bfd_pkg::PIX_W-1:0]         avg_d,
	output logic [bfd_pkg::OUT_COORD_W-1:0]   out_col,
	output logic [bfd_pkg::OUT_COORD_W-1:0]   out_row,
	output logic                              frame_last
);
	import bfd_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WLW = $clog2(MAX_WIDTH + 1);
	localparam int HLW = $clog2(MAX_HEIGHT + 1);
	// Compare widths: wide enough for the raw register, the limit and a
	// sum of a position and two factors.
	localparam int XW  = ((WLW > CFG_W) ? WLW : CFG_W) + 2;
	localparam int YW  = ((HLW > CFG_W) ? HLW : CFG_W) + 2;
	localparam int FCW = FACT_W + 2;

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0]   src_width_q;
	logic [CFG_W-1:0]   src_height_q;
	logic [FACT_W-1:0]  fx_q;
	logic [FACT_W-1:0]  fy_q;
	logic [CHCNT_W-1:0] ch_cnt_q;
	logic               restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= CFG_W'(MAX_WIDTH_DEF);
			src_height_q <= CFG_W'(MAX_HEIGHT_DEF);
			fx_q         <= FACT_W'(2);
			fy_q         <= FACT_W'(2);
			ch_cnt_q     <= CH_RGBA;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_SRC_WIDTH:     src_width_q  <= wr_data;
				REG_SRC_HEIGHT:    src_height_q <= wr_data;
				REG_FACTOR_X:      fx_q         <= wr_data[FACT_W-1:0];
				REG_FACTOR_Y:      fy_q         <= wr_data[FACT_W-1:0];
				REG_CHANNEL_COUNT: ch_cnt_q     <= wr_data[CHCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Any write to a listed register restarts the frame.
	always_comb begin
		restart = 1'b0;
		if (wr_en) begin
			unique case (wr_index) inside
				REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_FACTOR_X, REG_FACTOR_Y,
				REG_CHANNEL_COUNT: restart = 1'b1;
				default:           restart = 1'b0;
			endcase
		end
	end

	// ---------------- frame geometry ----------------
	logic [XW-1:0] w_full;
	logic [YW-1:0] h_full;
	logic          dims_ok;
	logic          active;
	logic          nch4;

	// Saturate the raw dimensions to the storage limits.
	assign w_full = (XW'(src_width_q) > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : XW'(src_width_q);
	assign h_full = (YW'(src_height_q) > YW'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT)
		: YW'(src_height_q);
	assign dims_ok = (w_full != '0) && (h_full != '0);
	assign nch4    = (ch_cnt_q == CH_RGBA);

	// Filter runs only with legal factors that fit the image and are not
	// both one.
	assign active = (fx_q != '0) && (FCW'(fx_q) <= FCW'(MAX_FACTOR))
		&& (fy_q != '0) && (FCW'(fy_q) <= FCW'(MAX_FACTOR))
		&& !((fx_q == FACT_W'(1)) && (fy_q == FACT_W'(1)))
		&& (XW'(fx_q) <= w_full) && (YW'(fy_q) <= h_full);

	// ---------------- position state ----------------
	logic [CW-1:0]     in_col_q, in_col_d;
	logic [RW-1:0]     in_row_q, in_row_d;
	logic [FACT_W-1:0] cib_q, cib_d;
	logic [FACT_W-1:0] rib_q, rib_d;
	logic [CW-1:0]     ocol_q, ocol_d;
	logic [RW-1:0]     orow_q, orow_d;
	part_vec_t         part_q, part_d;
	part_vec_t         part_sum;
	byte_vec_t         pix;

	logic col_fit, row_fit, in_range, row_act;
	logic block_done, band_last, last_col, last_row, row_end, frame_end;
	logic take_block;
	logic pix_xfer, res_xfer;

	assign pix = {chan_d, chan_c, chan_b, chan_a};

	// A pixel lies inside the covered area when its block (band) still fits
	// entirely inside the image.
	assign col_fit = (XW'(in_col_q) - XW'(cib_q) + XW'(fx_q)) <= w_full;
	assign row_fit = (YW'(in_row_q) - YW'(rib_q) + YW'(fy_q)) <= h_full;
	assign in_range = active && col_fit && row_fit;
	assign row_act  = active && row_fit;

	assign block_done = (FCW'(cib_q) + FCW'(1)) >= FCW'(fx_q);
	assign band_last  = (FCW'(rib_q) + FCW'(1)) >= FCW'(fy_q);
	// No further block fits to the right / below.
	assign last_col   = (XW'(in_col_q) + XW'(1) + XW'(fx_q)) > w_full;
	assign last_row   = (YW'(in_row_q) + YW'(1) + YW'(fy_q)) > h_full;
	assign row_end    = (XW'(in_col_q) + XW'(1)) >= w_full;
	assign frame_end  = (YW'(in_row_q) + YW'(1)) >= h_full;

	assign take_block = in_range && block_done;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (i < LANES - 1 || nch4) begin
				part_sum[i] = part_q[i] + PART_W'(pix[i]);
			end else begin
				part_sum[i] = part_q[i];
			end
		end
	end

	always_comb begin
		in_col_d = in_col_q;
		in_row_d = in_row_q;
		cib_d    = cib_q;
		rib_d    = rib_q;
		ocol_d   = ocol_q;
		orow_d   = orow_q;
		part_d   = part_q;
		if (in_range) begin
			if (block_done) begin
				part_d = '0;
				cib_d  = '0;
				ocol_d = ocol_q + 1'b1;
			end else begin
				part_d = part_sum;
				cib_d  = cib_q + 1'b1;
			end
		end
		if (row_end) begin
			// wrap to the next source row
			in_col_d = '0;
			cib_d    = '0;
			ocol_d   = '0;
			part_d   = '0;
			if (row_act) begin
				if (band_last) begin
					rib_d  = '0;
					orow_d = orow_q + 1'b1;
				end else begin
					rib_d = rib_q + 1'b1;
				end
			end
			if (frame_end) begin
				in_row_d = '0;
				rib_d    = '0;
				orow_d   = '0;
			end else begin
				in_row_d = in_row_q + 1'b1;
			end
		end else begin
			in_col_d = in_col_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q <= '0;
			in_row_q <= '0;
			cib_q    <= '0;
			rib_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			part_q   <= '0;
		end else if (restart) begin
			in_col_q <= '0;
			in_row_q <= '0;
			cib_q    <= '0;
			rib_q    <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			part_q   <= '0;
		end else if (pix_xfer && dims_ok) begin
			in_col_q <= in_col_d;
			in_row_q <= in_row_d;
			cib_q    <= cib_d;
			rib_q    <= rib_d;
			ocol_q   <= ocol_d;
			orow_q   <= orow_d;
			part_q   <= part_d;
		end
	end

	// ---------------- finished block snapshot ----------------
	part_vec_t     part_s1;
	logic [CW-1:0] idx_s1;
	logic [RW-1:0] orow_s1;
	logic          rib0_s1;
	logic          emit_s1;
	logic          last_s1;
	logic          nch4_s1;

	// Hold the closing block's sums and coordinates for the merge.
	always_ff @(posedge clk) begin
		if (pix_xfer && take_block) begin
			part_s1 <= part_sum;
			idx_s1  <= ocol_q;
			orow_s1 <= orow_q;
			rib0_s1 <= (rib_q == '0);
			emit_s1 <= band_last;
			last_s1 <= last_col && last_row;
			nch4_s1 <= nch4;
		end
	end

	// ---------------- column sum memory ----------------
	sum_vec_t mem_rd_data;
	sum_vec_t merged;
	logic     mem_wr_en;

	bfd_colmem #(
		.DEPTH(MAX_WIDTH)
	) u_colmem (
		.clk    (clk),
		.rd_en  (pix_xfer && take_block),
		.rd_addr(ocol_q),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(idx_s1),
		.wr_data(merged)
	);

	// First row of a band starts the column sum afresh.
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			merged[i] = (rib0_s1 ? '0 : mem_rd_data[i]) + SUM_W'(part_s1[i]);
		end
	end

	// ---------------- divider ----------------
	logic              div_start;
	logic              div_done;
	byte_vec_t         quotient;
	logic [AREA_W-1:0] area;

	assign area = AREA_W'(fx_q) * AREA_W'(fy_q);

	bfd_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(merged),
		.divisor (area),
		.done    (div_done),
		.quotient(quotient)
	);

	// ---------------- controller ----------------
	bfd_state_t state_q, state_d;
	logic       load_out;
	logic       res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pix_stall = 1'b1;
		mem_wr_en = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pix_stall = 1'b0;
				if (pix_valid && take_block) begin
					state_d = ST_MERGE;
				end
			end
			ST_MERGE: begin
				// read data is back: merge and write the column sum
				mem_wr_en = 1'b1;
				if (emit_s1) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				// hand over once the output register is free or draining
				if (!res_valid_q || !res_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign pix_xfer = pix_valid && !pix_stall;
	assign res_xfer = res_valid_q && !res_stall;

	// ---------------- output register ----------------
	byte_vec_t              avg_q;
	logic [OUT_COORD_W-1:0] out_col_q;
	logic [OUT_COORD_W-1:0] out_row_q;
	logic                   frame_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_xfer) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			avg_q[0]     <= quotient[0];
			avg_q[1]     <= quotient[1];
			avg_q[2]     <= quotient[2];
			avg_q[3]     <= nch4_s1 ? quotient[3] : '0;
			out_col_q    <= OUT_COORD_W'(idx_s1);
			out_row_q    <= OUT_COORD_W'(orow_s1);
			frame_last_q <= last_s1;
		end
	end

	assign res_valid  = res_valid_q;
	assign avg_a      = avg_q[0];
	assign avg_b      = avg_q[1];
	assign avg_c      = avg_q[2];
	assign avg_d      = avg_q[3];
	assign out_col    = out_col_q;
	assign out_row    = out_row_q;
	assign frame_last = frame_last_q;

	// ---------------- assertions ----------------
	`BFD_ASSERT(a_done_only_in_div, div_done |-> state_q == ST_DIV)
	`BFD_ASSERT(a_block_goes_to_merge, (pix_xfer && take_block) |=> state_q == ST_MERGE)
	`BFD_ASSERT(a_push_after_div, state_q == ST_PUSH |-> $past(state_q) == ST_DIV || $past(state_q) == ST_PUSH)
	`BFD_ASSERT(a_rgb_alpha_zero, ($rose(res_valid_q) && !$past(nch4_s1)) |-> avg_d == '0)
	`BFD_ASSERT_NEVER(a_no_load_over_full, load_out && res_valid_q && res_stall)

endmodule

// ----- hdl/bfd_colmem.sv -----
// ----------------------------------------------------------------------------
// Column sum memory
// One entry per output column holding four 16-bit channel sums of the band.
// Synchronous write, synchronous read with registered data.
// ----------------------------------------------------------------------------
module bfd_colmem #(
	parameter int DEPTH = bfd_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output bfd_pkg::sum_vec_t        rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  bfd_pkg::sum_vec_t        wr_data
);
	import bfd_pkg::*;

	sum_vec_t mem [DEPTH];
	sum_vec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/bfd_div.sv -----
// ----------------------------------------------------------------------------
// Block average divider
// Restoring division of four channel sums by the block area, one quotient
// bit per cycle. The quotient never exceeds 8 bits, so eight steps suffice.
// ----------------------------------------------------------------------------
module bfd_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  bfd_pkg::sum_vec_t            dividend,
	input  logic [bfd_pkg::AREA_W-1:0]   divisor,
	output logic                         done,
	output bfd_pkg::byte_vec_t           quotient
);
	import bfd_pkg::*;

	localparam int DSH_W = AREA_W + PIX_W - 1;
	localparam int CNT_W = $clog2(PIX_W);
	localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(PIX_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DSH_W-1:0] dsh_q;
	sum_vec_t         rem_q;
	byte_vec_t        quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shifted divisor walks from area << 7 down to area.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= DSH_W'(divisor) << (PIX_W - 1);
		end else if (busy_q) begin
			for (int i = 0; i < LANES; i++) begin
				if (DSH_W'(rem_q[i]) >= dsh_q) begin
					rem_q[i] <= rem_q[i] - SUM_W'(dsh_q);
					quo_q[i] <= {quo_q[i][PIX_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][PIX_W-2:0], 1'b0};
				end
			end
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- tb/sv/tb_box_filter_image_downscaler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box filter image downscaler testbench
// Streams raster pixels through the downscaler under a range of frame sizes,
// block factors and channel counts. An in-bench predictor tracks the block
// sums and positions and queues the reduced pixels that must come out; each
// result transfer is checked field by field against the oldest of them.
// ----------------------------------------------------------------------------
module tb_box_filter_image_downscaler;
	import bfd_pkg::*;

	// Run limits: watchdog budget, settle wait and random item budget.
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 16;   // lets the slowest pixel finish
	localparam int RANDOM_ITEMS  = 920;

	localparam logic [CHCNT_W-1:0] CH_RGB = 3'd3;

	typedef enum {
		STALL_NONE,
		STALL_HALF,
		STALL_LIGHT,
		STALL_HOLD
	} stall_mode_e;

	// One reduced pixel, in port order.
	typedef struct packed {
		logic [PIX_W-1:0]       avg_a;
		logic [PIX_W-1:0]       avg_b;
		logic [PIX_W-1:0]       avg_c;
		logic [PIX_W-1:0]       avg_d;
		logic [OUT_COORD_W-1:0] out_col;
		logic [OUT_COORD_W-1:0] out_row;
		logic                   frame_last;
	} avg_pix_t;

	logic                   clk;
	logic                   arst_n;
	logic                   wr_en;
	logic [REG_IDX_W-1:0]   wr_index;
	logic [CFG_W-1:0]       wr_data;
	logic                   pix_valid;
	logic                   pix_stall;
	logic [PIX_W-1:0]       chan_a;
	logic [PIX_W-1:0]       chan_b;
	logic [PIX_W-1:0]       chan_c;
	logic [PIX_W-1:0]       chan_d;
	logic                   res_valid;
	logic                   res_stall;
	logic [PIX_W-1:0]       avg_a;
	logic [PIX_W-1:0]       avg_b;
	logic [PIX_W-1:0]       avg_c;
	logic [PIX_W-1:0]       avg_d;
	logic [OUT_COORD_W-1:0] out_col;
	logic [OUT_COORD_W-1:0] out_row;
	logic                   frame_last;

	// Predictor copy of the registers, at their reset values.
	logic [CFG_W-1:0]   cfg_width  = 11'd1024;
	logic [CFG_W-1:0]   cfg_height = 11'd1024;
	logic [FACT_W-1:0]  cfg_fx     = 5'd2;
	logic [FACT_W-1:0]  cfg_fy     = 5'd2;
	logic [CHCNT_W-1:0] cfg_chans  = CH_RGBA;

	// Predictor state: per-column band sums, the running block row sum and
	// the source / block / reduced-image positions.
	sum_vec_t  col_sums [MAX_WIDTH_DEF];
	part_vec_t blk_part = '0;
	int src_col = 0, src_row = 0, blk_col = 0, band_row = 0;
	int dst_col = 0, dst_row = 0;

	avg_pix_t pending_avgs[$];
	int fail_count = 0;
	int cycle_count = 0;
	int burst_left = 8;
	bit held_once = 0;

	box_filter_image_downscaler DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.chan_a     (chan_a),
		.chan_b     (chan_b),
		.chan_c     (chan_c),
		.chan_d     (chan_d),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.avg_a      (avg_a),
		.avg_b      (avg_b),
		.avg_c      (avg_c),
		.avg_d      (avg_d),
		.out_col    (out_col),
		.out_row    (out_row),
		.frame_last (frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Clamp a size register to the block's maximum dimension.
	function automatic int eff_dim(input logic [CFG_W-1:0] v, input int cap);
		return (v > cap) ? cap : int'(v);
	endfunction

	// True when the current settings make the block produce averages.
	function automatic bit block_live();
		int w, h, fx, fy;
		w = eff_dim(cfg_width, MAX_WIDTH_DEF);
		h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
		fx = int'(cfg_fx);
		fy = int'(cfg_fy);
		return w != 0 && h != 0 && fx >= 1 && fx <= MAX_FACTOR && fy >= 1 &&
			fy <= MAX_FACTOR && !(fx == 1 && fy == 1) && fx <= w && fy <= h;
	endfunction

	// Fold one accepted pixel into the predicted sums; queue the reduced
	// pixel when it closes a block on the last row of a band.
	task automatic fold_pixel(input byte_vec_t px);
		int w, h, fx, fy, nch, nw, nh, area, idx, c;
		bit live;
		sum_vec_t base, merged;
		avg_pix_t res;
		w = eff_dim(cfg_width, MAX_WIDTH_DEF);
		h = eff_dim(cfg_height, MAX_HEIGHT_DEF);
		fx = int'(cfg_fx);
		fy = int'(cfg_fy);
		nch = (cfg_chans == CH_RGBA) ? 4 : 3;
		nw = 0;
		nh = 0;
		// Zero width or height: the position holds.
		if (w == 0 || h == 0)
			return;
		live = block_live();
		if (live) begin
			nw = w / fx;
			nh = h / fy;
		end
		if (live && src_col < nw * fx && src_row < nh * fy) begin
			for (c = 0; c < nch; c++)
				blk_part[c] = blk_part[c] + PART_W'(px[c]);
			if (blk_col + 1 >= fx) begin
				idx = (dst_col < MAX_WIDTH_DEF) ? dst_col : MAX_WIDTH_DEF - 1;
				base = (band_row == 0) ? '0 : col_sums[idx];
				for (c = 0; c < LANES; c++)
					merged[c] = base[c] + SUM_W'(blk_part[c]);
				col_sums[idx] = merged;
				blk_part = '0;
				if (band_row + 1 >= fy) begin
					area = fx * fy;
					res.avg_a = PIX_W'(merged[0] / area);
					res.avg_b = PIX_W'(merged[1] / area);
					res.avg_c = PIX_W'(merged[2] / area);
					res.avg_d = (nch == 4) ? PIX_W'(merged[3] / area) : '0;
					res.out_col = dst_col[OUT_COORD_W-1:0];
					res.out_row = dst_row[OUT_COORD_W-1:0];
					res.frame_last = (dst_col + 1 == nw && dst_row + 1 == nh);
					pending_avgs.push_back(res);
				end
				blk_col = 0;
				dst_col++;
			end else begin
				blk_col++;
			end
		end
		src_col++;
		if (src_col >= w) begin
			src_col = 0;
			blk_col = 0;
			dst_col = 0;
			blk_part = '0;
			if (live && src_row < nh * fy) begin
				if (band_row + 1 >= fy) begin
					band_row = 0;
					dst_row++;
				end else begin
					band_row++;
				end
			end
			src_row++;
			// Wrap to a new frame after the last source row.
			if (src_row >= h) begin
				src_row = 0;
				band_row = 0;
				dst_row = 0;
			end
		end
	endtask

	// Write one register; call at a falling edge. A listed register also
	// restarts the frame, an unlisted index changes nothing.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
		REG_SRC_WIDTH:     cfg_width = data;
		REG_SRC_HEIGHT:    cfg_height = data;
		REG_FACTOR_X:      cfg_fx = data[FACT_W-1:0];
		REG_FACTOR_Y:      cfg_fy = data[FACT_W-1:0];
		REG_CHANNEL_COUNT: cfg_chans = data[CHCNT_W-1:0];
		default:           return;
		endcase
		blk_part = '0;
		src_col = 0;
		src_row = 0;
		blk_col = 0;
		band_row = 0;
		dst_col = 0;
		dst_row = 0;
	endtask

	// Drop valid, let every expected result drain, then let the block
	// finish any pixel that closes no output.
	task automatic wait_idle();
		pix_valid = 1'b0;
		while (pending_avgs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input int w, input int h, input int fx, input int fy,
			input logic [CHCNT_W-1:0] ch);
		wait_idle();
		write_reg(REG_SRC_WIDTH, CFG_W'(w));
		write_reg(REG_SRC_HEIGHT, CFG_W'(h));
		write_reg(REG_FACTOR_X, CFG_W'(fx));
		write_reg(REG_FACTOR_Y, CFG_W'(fy));
		write_reg(REG_CHANNEL_COUNT, CFG_W'(ch));
	endtask

	// Offer one pixel and hold it until the transfer; call at a falling
	// edge. Bursts end with a random gap on the valid line.
	task automatic send_pixel(input byte_vec_t px);
		chan_a = px[0];
		chan_b = px[1];
		chan_c = px[2];
		chan_d = px[3];
		pix_valid = 1'b1;
		do
			@(posedge clk);
		while (pix_stall);
		@(negedge clk);
		fold_pixel(px);
		burst_left--;
		if (burst_left <= 0) begin
			pix_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			// Now and then run a long burst with no gaps at all.
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
	endtask

	function automatic byte_vec_t random_pixel();
		byte_vec_t px;
		int c;
		for (c = 0; c < LANES; c++)
			case ($urandom_range(0, 9))
			0:       px[c] = 8'h00;
			1:       px[c] = 8'hFF;
			default: px[c] = PIX_W'($urandom_range(0, 255));
			endcase
		return px;
	endfunction

	// Mostly small factors, sometimes the largest.
	function automatic int pick_factor();
		case ($urandom_range(0, 9)) inside
		0, 1:    return 1;
		2:       return MAX_FACTOR;
		3:       return $urandom_range(5, MAX_FACTOR);
		default: return $urandom_range(2, 4);
		endcase
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Full-value blocks: one of all ones, one of all zeros.
	task automatic test_extreme_values();
		configure(4, 1, 2, 1, CH_RGBA);
		send_pixel('1);
		send_pixel('1);
		send_pixel('0);
		send_pixel('0);
	endtask

	// Three channels, with the odd column and row dropped.
	task automatic test_rgb_crop();
		byte_vec_t px;
		int k;
		configure(3, 3, 2, 2, CH_RGB);
		for (k = 0; k < 9; k++) begin
			px = random_pixel();
			px[3] = 8'hFF;
			send_pixel(px);
		end
	endtask

	// Settings that leave the block with nothing to emit.
	task automatic test_inactive_settings();
		configure(2, 2, 1, 1, CH_RGBA);   // both factors one
		send_pixel(random_pixel());
		configure(2, 2, 0, 2, CH_RGBA);   // zero factor
		send_pixel(random_pixel());
		configure(2, 2, 31, 2, CH_RGBA);  // factor past the maximum
		send_pixel(random_pixel());
		configure(2, 2, 3, 2, CH_RGBA);   // factor wider than the frame
		send_pixel(random_pixel());
		configure(0, 2, 2, 2, CH_RGBA);   // zero width
		send_pixel(random_pixel());
		configure(2, 0, 2, 2, CH_RGBA);   // zero height
		send_pixel(random_pixel());
	endtask

	// A write to an unlisted index must keep the partial block; a listed
	// write must throw it away.
	task automatic test_frame_restart();
		configure(2, 1, 2, 1, CH_RGBA);
		send_pixel(random_pixel());
		wait_idle();
		write_reg(3'(REG_CHANNEL_COUNT) + 3'($urandom_range(1, 3)),
			CFG_W'($urandom_range(0, 2047)));
		send_pixel(random_pixel());
		send_pixel(random_pixel());
		wait_idle();
		write_reg(REG_FACTOR_Y, CFG_W'(1));
		send_pixel(random_pixel());
		send_pixel(random_pixel());
	endtask

	// Random settings, mostly whole frames of random pixels, some cut short,
	// plus a share of broken settings.
	task automatic test_random_frames();
		int sent, w, h, fx, fy, frame_px, n, k;
		bit live_now;
		logic [CHCNT_W-1:0] ch;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 6) == 0) begin
				w = $urandom_range(0, 40);
				h = $urandom_range(0, 20);
				fx = $urandom_range(0, 31);
				fy = $urandom_range(0, 31);
			end else begin
				fx = pick_factor();
				fy = pick_factor();
				w = fx * $urandom_range(1, 4);
				h = fy * $urandom_range(1, 4);
				if ($urandom_range(0, 3) == 0)
					w += $urandom_range(0, fx - 1);
				if ($urandom_range(0, 3) == 0)
					h += $urandom_range(0, fy - 1);
				// Keep big blocks to one block per frame.
				if (w * h > 400) begin
					w = fx;
					h = fy;
				end
			end
			if ($urandom_range(0, 1))
				ch = CHCNT_W'($urandom_range(0, 7));
			else
				ch = $urandom_range(0, 1) ? CH_RGBA : CH_RGB;
			configure(w, h, fx, fy, ch);
			if ($urandom_range(0, 4) == 0)
				write_reg(3'(REG_CHANNEL_COUNT) + 3'($urandom_range(1, 3)),
					CFG_W'($urandom_range(0, 2047)));
			live_now = block_live();
			frame_px = w * h;
			if (!live_now) begin
				n = $urandom_range(1, 12);
			end else begin
				n = frame_px * ((frame_px <= 200) ? $urandom_range(1, 2) : 1);
				if ($urandom_range(0, 3) == 0)
					n += $urandom_range(1, frame_px);
			end
			// Stay within the item budget; the last frame may be cut short.
			if (n > RANDOM_ITEMS - sent)
				n = RANDOM_ITEMS - sent;
			sent += n;
			for (k = 0; k < n; k++) begin
				send_pixel(random_pixel());
				// Hold the stream until every queued average has come out.
				if ((live_now && !held_once && k == n / 2) || $urandom_range(0, 49) == 0) begin
					pix_valid = 1'b0;
					while (pending_avgs.size() != 0)
						@(negedge clk);
					held_once = 1;
				end
			end
		end
	endtask

	// Receiver: stall in modes of random length, from none to solid.
	initial begin
		stall_mode_e mode;
		int span;
		res_stall = 1'b0;
		forever begin
			mode = stall_mode_e'($urandom_range(0, 3));
			span = (mode == STALL_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
			repeat (span) begin
				@(negedge clk);
				case (mode)
				STALL_NONE:  res_stall = 1'b0;
				STALL_HALF:  res_stall = 1'($urandom_range(0, 1));
				STALL_LIGHT: res_stall = ($urandom_range(0, 3) == 0);
				default:     res_stall = 1'b1;
				endcase
			end
		end
	end

	// Check every result transfer against the oldest queued average.
	always @(posedge clk) begin
		avg_pix_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_avgs.size() == 0) begin
				$error("result with none expected: col %0d row %0d", out_col, out_row);
				fail_count++;
			end else begin
				want = pending_avgs.pop_front();
				check_field("avg_a", want.avg_a, avg_a);
				check_field("avg_b", want.avg_b, avg_b);
				check_field("avg_c", want.avg_c, avg_c);
				check_field("avg_d", want.avg_d, avg_d);
				check_field("out_col", want.out_col, out_col);
				check_field("out_row", want.out_row, out_row);
				check_field("frame_last", want.frame_last, frame_last);
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_box_filter_image_downscaler: errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		pix_valid = 1'b0;
		chan_a = '0;
		chan_b = '0;
		chan_c = '0;
		chan_d = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		test_extreme_values();
		test_rgb_crop();
		test_inactive_settings();
		test_frame_restart();
		test_random_frames();

		// Drain, then leave room for any stray result.
		wait_idle();
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("tb_box_filter_image_downscaler: clean");
		else
			$display("tb_box_filter_image_downscaler: errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bfd_pkg.sv
hdl/bfd_colmem.sv
hdl/bfd_div.sv
hdl/box_filter_image_downscaler.sv
tb/sv/tb_box_filter_image_downscaler.sv
